// File: rtl/core/gcm_pkg.sv
// Shared types and constants for the gradient color map pipeline.
package gcm_pkg;

    localparam int VALUE_W = 32;
    localparam int COLOR_W = 32;
    localparam int SLOT_W  = 4;
    localparam int CNT_W   = 5;
    localparam int CFG_W   = 2;

    localparam logic [COLOR_W-1:0] BLACK_ARGB = 32'hFF00_0000;

    // Configuration register indexes.
    localparam logic [CFG_W-1:0] CFG_MIN_VALUE    = 2'd0;
    localparam logic [CFG_W-1:0] CFG_MAX_VALUE    = 2'd1;
    localparam logic [CFG_W-1:0] CFG_COLOR_COUNT  = 2'd2;
    localparam logic [CFG_W-1:0] CFG_BLEND_ENABLE = 2'd3;

    // How a map word finds its color.
    typedef enum logic [1:0] {
        KIND_BLACK,
        KIND_FIRST,
        KIND_LAST,
        KIND_INTERP
    } kind_t;

    // Control and payload that travel with every word down the pipeline.
    typedef struct packed {
        logic               valid;
        logic               is_map;
        kind_t              kind;
        logic [CNT_W-1:0]   cnt_m1;
        logic [SLOT_W-1:0]  slot;
        logic [COLOR_W-1:0] color;
    } item_t;

endpackage

// File: rtl/core/gcm_classify.sv
// Entry stage: range checks, special cases and the dividend and divisor of the position.
module gcm_classify #(
    parameter int PALETTE_DEPTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic                          in_action,
    input  logic [gcm_pkg::SLOT_W-1:0]    in_slot,
    input  logic [gcm_pkg::COLOR_W-1:0]   in_color,
    input  logic [gcm_pkg::VALUE_W-1:0]   in_sample,
    input  logic [gcm_pkg::VALUE_W-1:0]   min_value,
    input  logic [gcm_pkg::VALUE_W-1:0]   max_value,
    input  logic [gcm_pkg::CNT_W-1:0]     color_count,
    output gcm_pkg::item_t                item,
    output logic [gcm_pkg::VALUE_W-1:0]   diff,
    output logic [gcm_pkg::VALUE_W-1:0]   span
);
    import gcm_pkg::*;

    logic signed [VALUE_W:0] sample_ext;
    logic signed [VALUE_W:0] lo_ext;
    logic signed [VALUE_W:0] hi_ext;
    logic signed [VALUE_W:0] diff_full;
    logic signed [VALUE_W:0] span_full;
    logic [CNT_W-1:0]        cnt;
    logic                    below;
    logic                    above;
    kind_t                   kind;
    item_t                   item_next;
    item_t                   item_reg;
    logic [VALUE_W-1:0]      diff_reg;
    logic [VALUE_W-1:0]      span_reg;

    assign sample_ext = signed'({in_sample[VALUE_W-1], in_sample});
    assign lo_ext     = signed'({min_value[VALUE_W-1], min_value});
    assign hi_ext     = signed'({max_value[VALUE_W-1], max_value});
    assign diff_full  = sample_ext - lo_ext;
    assign span_full  = hi_ext - lo_ext;
    assign below      = sample_ext <= lo_ext;
    assign above      = sample_ext >= hi_ext;

    // A count beyond the palette depth saturates.
    assign cnt = (9'(color_count) > 9'(PALETTE_DEPTH)) ? CNT_W'(PALETTE_DEPTH) : color_count;

    always_comb begin
        if (color_count == '0) begin
            kind = KIND_BLACK;
        end else if (cnt == CNT_W'(1) || below) begin
            kind = KIND_FIRST;
        end else if (above) begin
            kind = KIND_LAST;
        end else begin
            kind = KIND_INTERP;
        end
    end

    always_comb begin
        item_next        = '0;
        item_next.valid  = in_valid;
        item_next.is_map = in_action;
        item_next.kind   = kind;
        item_next.cnt_m1 = cnt - CNT_W'(1);
        item_next.slot   = in_slot;
        item_next.color  = in_color;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_reg.valid <= 1'b0;
        end else if (adv) begin
            item_reg <= item_next;
            diff_reg <= diff_full[VALUE_W-1:0];
            span_reg <= span_full[VALUE_W-1:0];
        end
    end

    assign item = item_reg;
    assign diff = diff_reg;
    assign span = span_reg;

endmodule

// File: rtl/core/gcm_divider.sv
// Pipelined restoring divider: one quotient bit of the range fraction per stage.
module gcm_divider #(
    parameter int FRAC_W = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          adv,
    input  gcm_pkg::item_t                item_in,
    input  logic [gcm_pkg::VALUE_W-1:0]   diff_in,
    input  logic [gcm_pkg::VALUE_W-1:0]   span_in,
    output gcm_pkg::item_t                item_out,
    output logic [FRAC_W-1:0]             quot
);
    import gcm_pkg::*;

    item_t              side_reg [FRAC_W];
    logic [VALUE_W-1:0] rem_reg  [FRAC_W];
    logic [VALUE_W-1:0] span_reg [FRAC_W];
    logic [FRAC_W-1:0]  q_reg    [FRAC_W];

    for (genvar k = 0; k < FRAC_W; k++) begin : g_stage
        item_t              side_in;
        logic [VALUE_W-1:0] rem_in;
        logic [VALUE_W-1:0] span_st;
        logic [FRAC_W-1:0]  q_in;
        logic [VALUE_W:0]   rem2;
        logic [VALUE_W:0]   rem_sub;
        logic               ge;
        logic [VALUE_W-1:0] rem_next;
        logic [FRAC_W-1:0]  q_next;

        if (k == 0) begin : g_first
            assign side_in = item_in;
            assign rem_in  = diff_in;
            assign span_st = span_in;
            assign q_in    = '0;
        end else begin : g_next
            assign side_in = side_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign span_st = span_reg[k-1];
            assign q_in    = q_reg[k-1];
        end

        // The remainder stays below the span, so the doubled value fits one extra bit.
        assign rem2     = {rem_in, 1'b0};
        assign rem_sub  = rem2 - {1'b0, span_st};
        assign ge       = rem2 >= {1'b0, span_st};
        assign rem_next = ge ? rem_sub[VALUE_W-1:0] : rem2[VALUE_W-1:0];
        assign q_next   = {q_in[FRAC_W-2:0], ge};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                side_reg[k].valid <= 1'b0;
            end else if (adv) begin
                side_reg[k] <= side_in;
                rem_reg[k]  <= rem_next;
                span_reg[k] <= span_st;
                q_reg[k]    <= q_next;
            end
        end
    end

    assign item_out = side_reg[FRAC_W-1];
    assign quot     = q_reg[FRAC_W-1];

endmodule

// File: rtl/core/gcm_palette.sv
// Palette index and fraction from the range fraction, and the palette memory itself.
module gcm_palette #(
    parameter int PALETTE_DEPTH = 16,
    parameter int FRAC_W        = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          adv,
    input  gcm_pkg::item_t                item_in,
    input  logic [FRAC_W-1:0]             t_in,
    output gcm_pkg::item_t                item_out,
    output logic [FRAC_W-1:0]             frac,
    output logic                          take_upper,
    output logic [gcm_pkg::COLOR_W-1:0]   color_lo,
    output logic [gcm_pkg::COLOR_W-1:0]   color_hi
);
    import gcm_pkg::*;

    localparam int IDX_W = $clog2(PALETTE_DEPTH);
    localparam int POS_W = FRAC_W + CNT_W;

    logic [COLOR_W-1:0] mem [PALETTE_DEPTH];

    // Position stage.
    logic [POS_W-1:0]  pos;
    logic [CNT_W-1:0]  pos_idx;
    logic [CNT_W-1:0]  idx_next;
    logic [FRAC_W-1:0] frac_next;
    item_t             p1_item_reg;
    logic [CNT_W-1:0]  p1_idx_reg;
    logic [FRAC_W-1:0] p1_frac_reg;

    // Read stage.
    logic [8:0]         addr_lo_w;
    logic [8:0]         addr_hi_w;
    logic [IDX_W-1:0]   addr_lo;
    logic [IDX_W-1:0]   addr_hi;
    logic [8:0]         wr_slot_w;
    logic               wr_en;
    item_t              p2_item_reg;
    logic [FRAC_W-1:0]  p2_frac_reg;
    logic               p2_upper_reg;
    logic [COLOR_W-1:0] rd_lo_reg;
    logic [COLOR_W-1:0] rd_hi_reg;

    assign pos     = POS_W'(t_in) * POS_W'(item_in.cnt_m1);
    assign pos_idx = pos[POS_W-1:FRAC_W];

    always_comb begin
        idx_next  = '0;
        frac_next = '0;
        case (item_in.kind)
            KIND_INTERP: begin
                idx_next  = (pos_idx > item_in.cnt_m1 - CNT_W'(1)) ?
                            item_in.cnt_m1 - CNT_W'(1) : pos_idx;
                frac_next = pos[FRAC_W-1:0];
            end
            KIND_LAST: begin
                idx_next = item_in.cnt_m1;
            end
            default: begin
                idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_item_reg.valid <= 1'b0;
        end else if (adv) begin
            p1_item_reg <= item_in;
            p1_idx_reg  <= idx_next;
            p1_frac_reg <= frac_next;
        end
    end

    // Outside interpolation both ports read the same entry, so no unused slot is touched.
    assign addr_lo_w = 9'(p1_idx_reg);
    assign addr_hi_w = (p1_item_reg.kind == KIND_INTERP) ? 9'(p1_idx_reg) + 9'd1 :
                                                           9'(p1_idx_reg);
    assign addr_lo   = addr_lo_w[IDX_W-1:0];
    assign addr_hi   = addr_hi_w[IDX_W-1:0];

    // Loads write here, at the same stage where maps read, to keep stream order.
    assign wr_slot_w = 9'(p1_item_reg.slot);
    assign wr_en     = adv && p1_item_reg.valid && !p1_item_reg.is_map &&
                       (wr_slot_w < 9'(PALETTE_DEPTH));

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_slot_w[IDX_W-1:0]] <= p1_item_reg.color;
        end
        if (adv) begin
            rd_lo_reg <= mem[addr_lo];
            rd_hi_reg <= mem[addr_hi];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_item_reg.valid <= 1'b0;
        end else if (adv) begin
            p2_item_reg  <= p1_item_reg;
            p2_frac_reg  <= p1_frac_reg;
            p2_upper_reg <= (p1_item_reg.kind == KIND_INTERP) && p1_frac_reg[FRAC_W-1];
        end
    end

    assign item_out   = p2_item_reg;
    assign frac       = p2_frac_reg;
    assign take_upper = p2_upper_reg;
    assign color_lo   = rd_lo_reg;
    assign color_hi   = rd_hi_reg;

endmodule

// File: rtl/core/gcm_mix.sv
// Per-channel blend products, then rounding, clamping and the final color choice.
module gcm_mix #(
    parameter int FRAC_W = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          adv,
    input  logic                          blend_enable,
    input  gcm_pkg::item_t                item_in,
    input  logic [FRAC_W-1:0]             frac,
    input  logic                          take_upper,
    input  logic [gcm_pkg::COLOR_W-1:0]   color_lo,
    input  logic [gcm_pkg::COLOR_W-1:0]   color_hi,
    output gcm_pkg::item_t                item_out,
    output logic [gcm_pkg::COLOR_W-1:0]   color_out
);
    import gcm_pkg::*;

    localparam int LANES  = COLOR_W / 8;
    localparam int PROD_W = FRAC_W + 9;
    localparam int SUM_W  = PROD_W + 1;

    logic [FRAC_W:0]    one_minus;
    logic [PROD_W-1:0]  p_lo_reg [LANES];
    logic [PROD_W-1:0]  p_hi_reg [LANES];
    item_t              item_reg;
    logic               upper_reg;
    logic [COLOR_W-1:0] lo_reg;
    logic [COLOR_W-1:0] hi_reg;
    logic [COLOR_W-1:0] blended;

    assign one_minus = (FRAC_W+1)'(1 << FRAC_W) - {1'b0, frac};

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        logic [PROD_W-1:0] p_lo_next;
        logic [PROD_W-1:0] p_hi_next;
        logic [SUM_W-1:0]  sum;
        logic [SUM_W-FRAC_W-1:0] chan;

        assign p_lo_next = PROD_W'(color_lo[8*k +: 8]) * PROD_W'(one_minus);
        assign p_hi_next = PROD_W'(color_hi[8*k +: 8]) * PROD_W'(frac);

        always_ff @(posedge aclk) begin
            if (adv) begin
                p_lo_reg[k] <= p_lo_next;
                p_hi_reg[k] <= p_hi_next;
            end
        end

        // Round half up, then saturate to one byte.
        assign sum  = SUM_W'(p_lo_reg[k]) + SUM_W'(p_hi_reg[k]) + SUM_W'(1 << (FRAC_W - 1));
        assign chan = sum[SUM_W-1:FRAC_W];
        assign blended[8*k +: 8] = (chan > (SUM_W-FRAC_W)'(255)) ? 8'hFF : chan[7:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_reg.valid <= 1'b0;
        end else if (adv) begin
            item_reg  <= item_in;
            upper_reg <= take_upper;
            lo_reg    <= color_lo;
            hi_reg    <= color_hi;
        end
    end

    always_comb begin
        if (item_reg.kind == KIND_BLACK) begin
            color_out = BLACK_ARGB;
        end else if (blend_enable && item_reg.kind == KIND_INTERP) begin
            color_out = blended;
        end else if (upper_reg) begin
            color_out = hi_reg;
        end else begin
            color_out = lo_reg;
        end
    end

    assign item_out = item_reg;

endmodule

// File: rtl/core/gradient_color_map.sv
// Top level of the gradient color map: configuration registers, pipeline and output register.
//
//   Channel   Direction  Handshake            Payload
//   s_*       in         s_tvalid / s_tready  tuser: action; tdata: slot, color, sample
//   m_*       out        m_tvalid / m_tready  tdata: mapped ARGB color
//   cfg_*     in         cfg_wr_en            cfg_index, cfg_wdata
//
// One word is taken every clock unless the output stalls. A map word passes the entry register,
// the restoring divider stages, one fraction bit each, the palette position and read registers,
// the mix register and the output register. Load words travel the same pipeline and write the
// palette at its read stage. The palette has no reset and must be loaded before it is used.
// While an output word waits, every stage holds and s_tready is low.
module gradient_color_map #(
    parameter int PALETTE_DEPTH = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [71:0]                   s_tdata,  // entry_index, entry_color, sample_value, zero pad
    input  logic [0:0]                    s_tuser,  // action
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [gcm_pkg::COLOR_W-1:0]   m_tdata,  // mapped_color
    input  logic                          cfg_wr_en,
    input  logic [gcm_pkg::CFG_W-1:0]     cfg_index,
    input  logic [31:0]                   cfg_wdata
);
    import gcm_pkg::*;

    logic [VALUE_W-1:0] min_value_reg;
    logic [VALUE_W-1:0] max_value_reg;
    logic [CNT_W-1:0]   color_count_reg;
    logic               blend_enable_reg;

    logic                adv;
    item_t               cls_item;
    logic [VALUE_W-1:0]  cls_diff;
    logic [VALUE_W-1:0]  cls_span;
    item_t               div_item;
    logic [FRACTION_BITS-1:0] div_quot;
    item_t               pal_item;
    logic [FRACTION_BITS-1:0] pal_frac;
    logic                pal_upper;
    logic [COLOR_W-1:0]  pal_lo;
    logic [COLOR_W-1:0]  pal_hi;
    item_t               mix_item;
    logic [COLOR_W-1:0]  mix_color;
    logic                m_tvalid_reg;
    logic [COLOR_W-1:0]  m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_value_reg    <= '0;
            max_value_reg    <= 32'h0001_0000;
            color_count_reg  <= '0;
            blend_enable_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MIN_VALUE:    min_value_reg    <= cfg_wdata;
                CFG_MAX_VALUE:    max_value_reg    <= cfg_wdata;
                CFG_COLOR_COUNT:  color_count_reg  <= cfg_wdata[CNT_W-1:0];
                CFG_BLEND_ENABLE: blend_enable_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // The whole pipeline advances unless the output word is stalled.
    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    gcm_classify #(
        .PALETTE_DEPTH(PALETTE_DEPTH)
    ) u_classify (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .adv         (adv),
        .in_valid    (s_tvalid),
        .in_action   (s_tuser[0]),
        .in_slot     (s_tdata[3:0]),
        .in_color    (s_tdata[35:4]),
        .in_sample   (s_tdata[67:36]),
        .min_value   (min_value_reg),
        .max_value   (max_value_reg),
        .color_count (color_count_reg),
        .item        (cls_item),
        .diff        (cls_diff),
        .span        (cls_span)
    );

    gcm_divider #(
        .FRAC_W(FRACTION_BITS)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .item_in  (cls_item),
        .diff_in  (cls_diff),
        .span_in  (cls_span),
        .item_out (div_item),
        .quot     (div_quot)
    );

    gcm_palette #(
        .PALETTE_DEPTH(PALETTE_DEPTH),
        .FRAC_W       (FRACTION_BITS)
    ) u_palette (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .item_in    (div_item),
        .t_in       (div_quot),
        .item_out   (pal_item),
        .frac       (pal_frac),
        .take_upper (pal_upper),
        .color_lo   (pal_lo),
        .color_hi   (pal_hi)
    );

    gcm_mix #(
        .FRAC_W(FRACTION_BITS)
    ) u_mix (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .adv          (adv),
        .blend_enable (blend_enable_reg),
        .item_in      (pal_item),
        .frac         (pal_frac),
        .take_upper   (pal_upper),
        .color_lo     (pal_lo),
        .color_hi     (pal_hi),
        .item_out     (mix_item),
        .color_out    (mix_color)
    );

    // Only map words produce an output word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= mix_item.valid && mix_item.is_map;
            m_tdata_reg  <= mix_color;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_load_no_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (mix_item.valid && !mix_item.is_map && adv) |=> !m_tvalid)
        else $error("load word produced an output word");

    a_map_gives_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (mix_item.valid && mix_item.is_map && adv) |=> m_tvalid)
        else $error("map word was lost before the output register");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> cls_item.valid)
        else $error("accepted word did not enter the pipeline");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(pal_item) && $stable(mix_item))
        else $error("pipeline moved during an output stall");
`endif

endmodule
